// ----- design/asfc_pkg.sv -----
`default_nettype none
package asfc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 12;
   localparam int NUM_FACES        = 6;

   typedef enum logic [2:0] {
      OP_APPLY   = 3'd0,
      OP_CAPTURE = 3'd1,
      OP_SOLVE   = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_RESET   = 3'd4,
      OP_SET_CAL = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      STS_OK           = 3'd0,
      STS_BAD_FACE     = 3'd1,
      STS_NORM_RANGE   = 3'd2,
      STS_WRONG_DIR    = 3'd3,
      STS_TILTED       = 3'd4,
      STS_FACES_MISS   = 3'd5,
      STS_INCONSISTENT = 3'd6,
      STS_SCALE_UNSAFE = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DINIT,
      ST_DIV,
      ST_DWR,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

// ----- design/asfc_if.sv -----
`default_nettype none
interface asfc_req_if #(parameter int SAMPLE_WIDTH = asfc_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic [2:0]                     operation;
   logic [2:0]                     face;
   logic signed [SAMPLE_WIDTH-1:0] sample_x;
   logic signed [SAMPLE_WIDTH-1:0] sample_y;
   logic signed [SAMPLE_WIDTH-1:0] sample_z;
   logic signed [SAMPLE_WIDTH:0]   scale_x_in;
   logic signed [SAMPLE_WIDTH:0]   scale_y_in;
   logic signed [SAMPLE_WIDTH:0]   scale_z_in;

   modport source (output valid, operation, face, sample_x, sample_y, sample_z,
                   scale_x_in, scale_y_in, scale_z_in, input ready);
   modport sink   (input valid, operation, face, sample_x, sample_y, sample_z,
                   scale_x_in, scale_y_in, scale_z_in, output ready);
endinterface

interface asfc_rsp_if #(parameter int SAMPLE_WIDTH = asfc_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_x;
   logic signed [SAMPLE_WIDTH-1:0] out_y;
   logic signed [SAMPLE_WIDTH-1:0] out_z;
   logic [2:0]                     status;
   logic                           calibrated;
   logic [5:0]                     faces_captured;

   modport source (output valid, out_x, out_y, out_z, status, calibrated, faces_captured,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, status, calibrated, faces_captured,
                   output ready);
endinterface
`default_nettype wire

// ----- design/accel_six_face_calibration.sv -----
`default_nettype none
// Six-position accelerometer calibrator. One transaction per operation, one response each.
// Everything runs through a single shared multiplier and a one-bit-per-cycle divider under a
// small sequencer; the block takes a new transaction only from idle. An apply runs three
// products through the multiplier; capture of a valid face runs three squares through the
// multiplier, then the checks; set calibration and a solve that fails its checks go through
// the checks only; clear, reset, unknown codes and capture of a bad face go straight to the
// response; a successful solve adds restoring division, one quotient bit per cycle, per axis.
// A finished response is held in an output register, and the next transaction is accepted
// while it waits.
module accel_six_face_calibration #(
   parameter int SAMPLE_WIDTH = asfc_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = asfc_pkg::FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   asfc_req_if.sink    req_chan,
   asfc_rsp_if.source  rsp_chan
);
   import asfc_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int PW   = 2*SW + 2;
   localparam int NW   = (2*SW + 2 > 2*FB + 3) ? 2*SW + 2 : 2*FB + 3;
   localparam int CW   = ((SW > FB) ? SW : FB) + 7;
   localparam int NB   = 2*FB + 2;
   localparam int CNTW = $clog2(NB + 1);
   localparam int RW   = SW + 2;

   localparam logic signed [PW-1:0] MAXV  = (PW'(1) <<< (SW-1)) - PW'(1);
   localparam logic signed [PW-1:0] MINV  = -MAXV - PW'(1);
   localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (FB-1);
   localparam logic [NW-1:0]        NLO   = NW'(9) << (2*FB-4);
   localparam logic [NW-1:0]        NHI   = NW'(25) << (2*FB-4);
   localparam logic signed [CW-1:0] U1    = CW'(1) <<< FB;
   localparam logic signed [CW-1:0] U3    = CW'(3) <<< FB;
   localparam logic signed [CW-1:0] U4    = CW'(4) <<< FB;
   localparam logic signed [CW-1:0] U10   = CW'(10) <<< FB;
   localparam logic signed [CW-1:0] U11   = CW'(11) <<< FB;
   localparam logic signed [CW-1:0] U16   = CW'(16) <<< FB;
   localparam logic [NB-1:0]        NUM2  = NB'(1) << (2*FB+1);
   localparam logic signed [SW:0]   ONE_S = (SW+1)'(1) <<< FB;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [2:0] face_ff;
   logic [1:0] ax_ff;
   logic [CNTW-1:0] cnt_ff;

   logic signed [SW-1:0] v_ff   [3];
   logic signed [SW:0]   scin_ff[3];
   logic signed [SW-1:0] res_ff [3];
   logic signed [SW-1:0] pos_ff [3];
   logic signed [SW-1:0] neg_ff [3];
   logic signed [SW-1:0] off_ff [3];
   logic signed [SW:0]   scl_ff [3];
   logic [5:0]  cap_ff;
   logic        calv_ff;
   status_type  status_ff;

   logic signed [PW-1:0] prod_ff;
   logic [NW-1:0]        acc_ff;
   logic [SW:0]          dd_ff;
   logic [RW-1:0]        rem_ff;
   logic [NB-1:0]        num_ff;
   logic [NB-1:0]        quo_ff;

   logic signed [SW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   status_type           rsp_status_ff;
   logic                 rsp_cal_ff;
   logic [5:0]           rsp_faces_ff;
   logic                 rsp_valid_ff;

   logic accept, rsp_free;
   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   op_type req_op;
   assign req_op = op_type'(req_chan.operation);

   // shared multiplier: offset-corrected sample times scale, or sample squared
   logic [1:0]           pax;
   logic signed [SW:0]   mul_a, mul_b;
   logic signed [PW-1:0] rnd, shr;
   logic signed [SW-1:0] sat_res;
   assign pax = ax_ff - 2'd1;

   always_comb begin
      if (op_ff == OP_APPLY) begin
         mul_a = (SW+1)'(v_ff[ax_ff]) - (SW+1)'(off_ff[ax_ff]);
         mul_b = scl_ff[ax_ff];
      end else begin
         mul_a = (SW+1)'(v_ff[ax_ff]);
         mul_b = (SW+1)'(v_ff[ax_ff]);
      end
   end

   assign rnd = prod_ff + HALF;
   assign shr = rnd >>> FB;
   always_comb begin
      if (shr > MAXV) begin
         sat_res = MAXV[SW-1:0];
      end else if (shr < MINV) begin
         sat_res = MINV[SW-1:0];
      end else begin
         sat_res = shr[SW-1:0];
      end
   end

   // capture, solve and set-calibration checks
   logic [1:0]           fax;
   logic signed [CW-1:0] fa, fa5;
   logic                 norm_bad, dir_bad, tilt_bad;
   logic [2:0]           tilt_over;
   logic signed [CW-1:0] absv[3];
   logic signed [SW:0]   dsum[3];
   logic signed [SW:0]   dlt [3];
   logic signed [CW-1:0] d5  [3];
   logic [2:0]           d_bad, sc_bad;
   logic signed [CW-1:0] abss[3];

   assign fax = face_ff[2:1];
   assign fa  = CW'(v_ff[fax]);
   assign fa5 = fa + (fa <<< 2);
   assign norm_bad = (acc_ff < NLO) || (acc_ff > NHI);
   assign dir_bad  = face_ff[0] ? (fa5 > -U3) : (fa5 < U3);

   for (genvar i = 0; i < 3; i++) begin : g_axis
      assign absv[i] = v_ff[i][SW-1] ? -CW'(v_ff[i]) : CW'(v_ff[i]);
      assign tilt_over[i] = (fax != 2'(i)) && (((absv[i] <<< 4) + (absv[i] <<< 2)) > U11);
      assign dlt[i]  = (SW+1)'(pos_ff[i]) - (SW+1)'(neg_ff[i]);
      assign dsum[i] = (SW+1)'(pos_ff[i]) + (SW+1)'(neg_ff[i]);
      assign d5[i]   = CW'(dlt[i]) + (CW'(dlt[i]) <<< 2);
      assign d_bad[i] = (d5[i] < U4) || (d5[i] > U16);
      assign abss[i] = scin_ff[i][SW] ? -CW'(scin_ff[i]) : CW'(scin_ff[i]);
      assign sc_bad[i] = (((abss[i] <<< 3) + (abss[i] <<< 1)) < U1) || (abss[i] > U10);
   end
   assign tilt_bad = |tilt_over;

   // divider step
   logic [RW-1:0] rem2;
   logic          ge;
   assign rem2 = {rem_ff[RW-2:0], num_ff[NB-1]};
   assign ge   = rem2 >= {1'b0, dd_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_APPLY:   state_in = ST_MUL;
                  OP_CAPTURE: state_in = (req_chan.face < 3'(NUM_FACES)) ? ST_MUL : ST_FIN;
                  OP_SOLVE:   state_in = ST_CHECK;
                  OP_SET_CAL: state_in = ST_CHECK;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_MUL: begin
            if (ax_ff == 2'd3) begin
               state_in = (op_ff == OP_APPLY) ? ST_FIN : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (op_ff == OP_SOLVE && cap_ff == 6'h3f && d_bad == 3'b000) begin
               state_in = ST_DINIT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DINIT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNTW'(NB-1)) begin
               state_in = ST_DWR;
            end
         end
         ST_DWR:   state_in = (ax_ff == 2'd2) ? ST_FIN : ST_DINIT;
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= '0;
         calv_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            neg_ff[i] <= '0;
            off_ff[i] <= '0;
            scl_ff[i] <= ONE_S;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff      <= req_op;
                  face_ff    <= req_chan.face;
                  v_ff[0]    <= req_chan.sample_x;
                  v_ff[1]    <= req_chan.sample_y;
                  v_ff[2]    <= req_chan.sample_z;
                  scin_ff[0] <= req_chan.scale_x_in;
                  scin_ff[1] <= req_chan.scale_y_in;
                  scin_ff[2] <= req_chan.scale_z_in;
                  ax_ff      <= '0;
                  acc_ff     <= '0;
                  status_ff  <= STS_OK;
                  for (int i = 0; i < 3; i++) begin
                     res_ff[i] <= '0;
                  end
                  if (req_op == OP_CAPTURE && req_chan.face >= 3'(NUM_FACES)) begin
                     status_ff <= STS_BAD_FACE;
                  end
                  if (req_op == OP_CLEAR || req_op == OP_RESET) begin
                     cap_ff <= '0;
                     for (int i = 0; i < 3; i++) begin
                        pos_ff[i] <= '0;
                        neg_ff[i] <= '0;
                     end
                  end
                  if (req_op == OP_RESET) begin
                     calv_ff <= 1'b0;
                     for (int i = 0; i < 3; i++) begin
                        off_ff[i] <= '0;
                        scl_ff[i] <= ONE_S;
                     end
                  end
               end
            end
            ST_MUL: begin
               if (ax_ff != 2'd3) begin
                  prod_ff <= PW'(mul_a) * PW'(mul_b);
               end
               if (ax_ff != 2'd0) begin
                  if (op_ff == OP_APPLY) begin
                     res_ff[pax] <= calv_ff ? sat_res : v_ff[pax];
                  end else begin
                     acc_ff <= acc_ff + NW'(prod_ff);
                  end
               end
               ax_ff <= ax_ff + 2'd1;
            end
            ST_CHECK: begin
               ax_ff <= '0;
               case (op_ff)
                  OP_CAPTURE: begin
                     if (norm_bad) begin
                        status_ff <= STS_NORM_RANGE;
                     end else if (dir_bad) begin
                        status_ff <= STS_WRONG_DIR;
                     end else if (tilt_bad) begin
                        status_ff <= STS_TILTED;
                     end else begin
                        // only the face's own axis is ever read back by solve
                        if (face_ff[0]) begin
                           neg_ff[fax] <= v_ff[fax];
                        end else begin
                           pos_ff[fax] <= v_ff[fax];
                        end
                        cap_ff[face_ff] <= 1'b1;
                     end
                  end
                  OP_SOLVE: begin
                     if (cap_ff != 6'h3f) begin
                        status_ff <= STS_FACES_MISS;
                     end else if (d_bad != 3'b000) begin
                        status_ff <= STS_INCONSISTENT;
                     end
                  end
                  OP_SET_CAL: begin
                     if (sc_bad != 3'b000) begin
                        status_ff <= STS_SCALE_UNSAFE;
                     end else begin
                        calv_ff <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                           off_ff[i] <= v_ff[i];
                           scl_ff[i] <= scin_ff[i];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ST_DINIT: begin
               // difference is positive here; numerator = 2*2^(2*FB) + d/2
               dd_ff  <= dlt[ax_ff];
               num_ff <= NUM2 + NB'(dlt[ax_ff][SW:1]);
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= '0;
            end
            ST_DIV: begin
               rem_ff <= ge ? (rem2 - {1'b0, dd_ff}) : rem2;
               num_ff <= num_ff << 1;
               quo_ff <= {quo_ff[NB-2:0], ge};
               cnt_ff <= cnt_ff + CNTW'(1);
            end
            ST_DWR: begin
               off_ff[ax_ff] <= dsum[ax_ff][SW:1];
               scl_ff[ax_ff] <= (SW+1)'(quo_ff);
               ax_ff         <= ax_ff + 2'd1;
               if (ax_ff == 2'd2) begin
                  calv_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_x_ff      <= res_ff[0];
         rsp_y_ff      <= res_ff[1];
         rsp_z_ff      <= res_ff[2];
         rsp_status_ff <= status_ff;
         rsp_cal_ff    <= calv_ff;
         rsp_faces_ff  <= cap_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_x          = rsp_x_ff;
   assign rsp_chan.out_y          = rsp_y_ff;
   assign rsp_chan.out_z          = rsp_z_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.calibrated     = rsp_cal_ff;
   assign rsp_chan.faces_captured = rsp_faces_ff;

`ifndef SYNTHESIS
   a_reset_op_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && op_ff == OP_RESET) |-> (!calv_ff && cap_ff == 6'h00))
      else $error("reset operation left calibration or faces behind");

   a_zero_unless_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && op_ff != OP_APPLY) |->
         (res_ff[0] == '0 && res_ff[1] == '0 && res_ff[2] == '0))
      else $error("nonzero sample on a non-apply transaction");

   a_apply_keeps_faces: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && op_ff == OP_APPLY) |=> $stable(cap_ff) && $stable(calv_ff))
      else $error("apply changed stored state");
`endif

endmodule
`default_nettype wire
